FILE: src/o2cfm_pkg.sv
// shared types, constants and state codes of the order-2 context model
package o2cfm_pkg;

   localparam int ALPHABET_DEF = 128;
   localparam int SYM_IN_W     = 7;
   localparam int CNT_W        = 32;
   localparam int SEEN_W       = 64;
   localparam int HALVE_BIT    = 31;
   localparam int MOD_W        = 27;

   localparam logic [SEEN_W-1:0] REBUILD_A = 64'd1000;
   localparam logic [SEEN_W-1:0] REBUILD_B = 64'd10000;
   localparam logic [SEEN_W-1:0] REBUILD_C = 64'd1000000;
   localparam logic [MOD_W-1:0]  REBUILD_PERIOD_M1 = 27'd99999999;

   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   typedef struct packed {
      logic                func;
      logic [SYM_IN_W-1:0] symbol_in;
      logic [CNT_W-1:0]    target_count;
   } req_type;

   typedef struct packed {
      logic [SYM_IN_W-1:0] symbol_out;
      logic [CNT_W-1:0]    cum_low;
      logic [CNT_W-1:0]    sym_freq;
      logic [CNT_W-1:0]    total_span;
      logic                model_active;
      logic                decode_fail;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SPAN,
      S_SRCH,
      S_LOW,
      S_UP,
      S_UPD,
      S_FAIL,
      S_RB_BUILD,
      S_RB_HALVE
   } state_type;

endpackage

FILE: src/o2cfm_ram.sv
// synchronous single write, single read memory with registered read data
module o2cfm_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

FILE: src/o2cfm_seq.sv
// sequencer: lookup, binary search, count update, rebuild and clearing pass
module o2cfm_seq #(
   parameter int ALPHABET = o2cfm_pkg::ALPHABET_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  o2cfm_pkg::req_type                            req_data,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output o2cfm_pkg::rsp_type                            rsp_data,
   output logic                                          f_we,
   output logic [$clog2(ALPHABET*ALPHABET*ALPHABET)-1:0] f_waddr,
   output logic [o2cfm_pkg::CNT_W-1:0]                   f_wdata,
   output logic [$clog2(ALPHABET*ALPHABET*ALPHABET)-1:0] f_raddr,
   input  logic [o2cfm_pkg::CNT_W-1:0]                   f_rdata,
   output logic                                          c_we,
   output logic [$clog2(ALPHABET*ALPHABET*ALPHABET)-1:0] c_waddr,
   output logic [o2cfm_pkg::CNT_W-1:0]                   c_wdata,
   output logic [$clog2(ALPHABET*ALPHABET*ALPHABET)-1:0] c_raddr,
   input  logic [o2cfm_pkg::CNT_W-1:0]                   c_rdata
);

   import o2cfm_pkg::*;

   localparam int DEPTH  = ALPHABET * ALPHABET * ALPHABET;
   localparam int ROWS   = ALPHABET * ALPHABET;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int SYM_W  = $clog2(ALPHABET);
   localparam int K_W    = SYM_W + 1;
   localparam int BIT_W  = (SYM_W > 1) ? $clog2(SYM_W) : 1;
   localparam int RUN_W  = CNT_W + K_W;

   localparam logic [SYM_W-1:0]  SYM_LAST  = SYM_W'(ALPHABET - 1);
   localparam logic [K_W-1:0]    K_END     = K_W'(ALPHABET);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ALPHABET);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [BIT_W-1:0]  BIT_TOP   = BIT_W'(SYM_W - 1);

   state_type state_ff, state_in;

   // control registers
   logic [SYM_W-1:0]  prev_old_ff, prev_old_in;
   logic [SYM_W-1:0]  prev_new_ff, prev_new_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [MOD_W-1:0]  mod_ff, mod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SYM_W-1:0]  clr_col_ff, clr_col_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              pend_ff, pend_in;

   // payload registers
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  span_ff, span_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [SYM_W-1:0]  lo_ff, lo_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CNT_W-1:0]  low_ff, low_in;
   logic [CNT_W-1:0]  fval_ff, fval_in;
   logic [ADDR_W-1:0] rb_base_ff, rb_base_in;
   logic [ROW_W-1:0]  rb_row_ff, rb_row_in;
   logic [SYM_W-1:0]  pidx_ff, pidx_in;
   logic [RUN_W-1:0]  run_ff, run_in;

   // shared decisions
   logic [ADDR_W-1:0] base_now;
   logic [CNT_W-1:0]  span_now;
   logic              span_fail;
   logic              slot_free;
   logic              active;
   logic [SEEN_W-1:0] seen_nx;
   logic [MOD_W-1:0]  mod_nx;
   logic              rb_trigger;
   logic              rb_row_done;
   logic              rb_over;
   logic [SYM_W-1:0]  cand;
   logic              cand_ok;
   logic              taken;
   logic [SYM_W-1:0]  lo_next;
   logic [SYM_W-1:0]  cand_nx;
   logic [SYM_W-1:0]  sym_sat;
   logic [CNT_W-1:0]  upper;

   assign base_now    = (ADDR_W'(prev_old_ff) * ROW_STEP + ADDR_W'(prev_new_ff)) * ROW_STEP;
   assign span_now    = c_rdata + f_rdata;
   assign span_fail   = req_ff.target_count >= span_now;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign active      = seen_ff >= SEEN_W'(2);
   assign seen_nx     = seen_ff + SEEN_W'(1);
   assign mod_nx      = (mod_ff == REBUILD_PERIOD_M1) ? '0 : mod_ff + MOD_W'(1);
   assign rb_trigger  = (seen_nx == REBUILD_A) || (seen_nx == REBUILD_B) ||
                        (seen_nx == REBUILD_C) || (mod_nx == '0);
   assign rb_row_done = (k_ff == K_END) && !pend_ff;
   assign rb_over     = |run_ff[RUN_W-1:HALVE_BIT];
   assign cand        = lo_ff | (SYM_W'(1) << bit_ff);
   assign cand_ok     = {1'b0, cand} < K_END;
   assign taken       = cand_ok && (c_rdata <= req_ff.target_count);
   assign lo_next     = taken ? cand : lo_ff;
   assign cand_nx     = lo_next | (SYM_W'(1) << (bit_ff - BIT_W'(1)));
   assign sym_sat     = (32'(req_ff.symbol_in) >= 32'(ALPHABET)) ? SYM_LAST
                                                                 : SYM_W'(req_ff.symbol_in);
   assign upper       = (sym_ff != SYM_LAST) ? c_rdata : span_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == ADDR_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_SPAN;
         end
         S_SPAN: begin
            if (req_ff.func == FUNC_ENCODE) state_in = S_LOW;
            else if (span_fail) state_in = S_FAIL;
            else state_in = S_SRCH;
         end
         S_SRCH: begin
            if (bit_ff == '0) state_in = S_LOW;
         end
         S_LOW: state_in = S_UP;
         S_UP:  state_in = S_UPD;
         S_UPD: begin
            if (slot_free) state_in = rb_trigger ? S_RB_BUILD : S_IDLE;
         end
         S_FAIL: begin
            if (slot_free) state_in = S_IDLE;
         end
         S_RB_BUILD: begin
            if (rb_row_done) begin
               if (rb_over) state_in = S_RB_HALVE;
               else if (rb_row_ff == ROW_LAST) state_in = S_IDLE;
            end
         end
         S_RB_HALVE: begin
            if (rb_row_done) state_in = S_RB_BUILD;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      req_ready    = 1'b0;
      f_we         = 1'b0;
      f_waddr      = '0;
      f_wdata      = '0;
      f_raddr      = '0;
      c_we         = 1'b0;
      c_waddr      = '0;
      c_wdata      = '0;
      c_raddr      = '0;
      prev_old_in  = prev_old_ff;
      prev_new_in  = prev_new_ff;
      seen_in      = seen_ff;
      mod_in       = mod_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_addr_in  = clr_addr_ff;
      clr_col_in   = clr_col_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      base_in      = base_ff;
      span_in      = span_ff;
      sym_in       = sym_ff;
      lo_in        = lo_ff;
      bit_in       = bit_ff;
      low_in       = low_ff;
      fval_in      = fval_ff;
      rb_base_in   = rb_base_ff;
      rb_row_in    = rb_row_ff;
      pidx_in      = pidx_ff;
      run_in       = run_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         // clearing pass: counts to one, lows to the column index
         S_CLEAR: begin
            f_we        = 1'b1;
            f_waddr     = clr_addr_ff;
            f_wdata     = CNT_W'(1);
            c_we        = 1'b1;
            c_waddr     = clr_addr_ff;
            c_wdata     = CNT_W'(clr_col_ff);
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            clr_col_in  = (clr_col_ff == SYM_LAST) ? '0 : clr_col_ff + SYM_W'(1);
         end
         // take a beat and read the last entry of the row
         S_IDLE: begin
            req_ready = 1'b1;
            f_raddr   = base_now + ADDR_W'(SYM_LAST);
            c_raddr   = base_now + ADDR_W'(SYM_LAST);
            if (req_valid) begin
               req_in  = req_data;
               base_in = base_now;
            end
         end
         // span known; start the search on a decode
         S_SPAN: begin
            span_in = span_now;
            sym_in  = sym_sat;
            lo_in   = '0;
            bit_in  = BIT_TOP;
            c_raddr = base_ff + ADDR_W'(SYM_W'(1) << BIT_TOP);
         end
         // one probe per cycle, highest bit first
         S_SRCH: begin
            lo_in = lo_next;
            if (bit_ff == '0) begin
               sym_in = lo_next;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
               if ({1'b0, cand_nx} < K_END) c_raddr = base_ff + ADDR_W'(cand_nx);
            end
         end
         S_LOW: begin
            c_raddr = base_ff + ADDR_W'(sym_ff);
            f_raddr = base_ff + ADDR_W'(sym_ff);
         end
         S_UP: begin
            low_in  = c_rdata;
            fval_in = f_rdata;
            if (sym_ff != SYM_LAST) c_raddr = base_ff + ADDR_W'(sym_ff) + ADDR_W'(1);
         end
         // deliver, bump the count once the model is active, and shift the context
         S_UPD: begin
            if (sym_ff != SYM_LAST) c_raddr = base_ff + ADDR_W'(sym_ff) + ADDR_W'(1);
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.symbol_out   = SYM_IN_W'(sym_ff);
               rsp_in.cum_low      = low_ff;
               rsp_in.sym_freq     = upper - low_ff;
               rsp_in.total_span   = span_ff;
               rsp_in.model_active = active;
               rsp_in.decode_fail  = 1'b0;
               if (active) begin
                  f_we    = 1'b1;
                  f_waddr = base_ff + ADDR_W'(sym_ff);
                  f_wdata = fval_ff + CNT_W'(1);
               end
               prev_old_in = prev_new_ff;
               prev_new_in = sym_ff;
               seen_in     = seen_nx;
               mod_in      = mod_nx;
               rb_base_in  = '0;
               rb_row_in   = '0;
               k_in        = '0;
               pend_in     = 1'b0;
               run_in      = '0;
            end
         end
         S_FAIL: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.symbol_out   = '0;
               rsp_in.cum_low      = '0;
               rsp_in.sym_freq     = '0;
               rsp_in.total_span   = span_ff;
               rsp_in.model_active = active;
               rsp_in.decode_fail  = 1'b1;
            end
         end
         // stream a row: lows from running sum, or halve the counts
         S_RB_BUILD, S_RB_HALVE: begin
            pend_in = 1'b0;
            if (k_ff != K_END) begin
               f_raddr = rb_base_ff + ADDR_W'(k_ff[SYM_W-1:0]);
               k_in    = k_ff + K_W'(1);
               pend_in = 1'b1;
               pidx_in = k_ff[SYM_W-1:0];
            end
            if (pend_ff) begin
               if (state_ff == S_RB_BUILD) begin
                  c_we    = 1'b1;
                  c_waddr = rb_base_ff + ADDR_W'(pidx_ff);
                  c_wdata = run_ff[CNT_W-1:0];
                  run_in  = run_ff + RUN_W'(f_rdata);
               end else begin
                  f_we    = 1'b1;
                  f_waddr = rb_base_ff + ADDR_W'(pidx_ff);
                  f_wdata = f_rdata - (f_rdata >> 1);
               end
            end
            if (rb_row_done) begin
               k_in   = '0;
               run_in = '0;
               if (state_ff == S_RB_BUILD && !rb_over) begin
                  rb_row_in  = rb_row_ff + ROW_W'(1);
                  rb_base_in = rb_base_ff + ROW_STEP;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         prev_old_ff  <= '0;
         prev_new_ff  <= '0;
         seen_ff      <= '0;
         mod_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
         clr_col_ff   <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_old_ff  <= prev_old_in;
         prev_new_ff  <= prev_new_in;
         seen_ff      <= seen_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_addr_ff  <= clr_addr_in;
         clr_col_ff   <= clr_col_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      base_ff    <= base_in;
      span_ff    <= span_in;
      sym_ff     <= sym_in;
      lo_ff      <= lo_in;
      bit_ff     <= bit_in;
      low_ff     <= low_in;
      fval_ff    <= fval_in;
      rb_base_ff <= rb_base_in;
      rb_row_ff  <= rb_row_in;
      pidx_ff    <= pidx_in;
      run_ff     <= run_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // count writes only from clearing, update or halving
   a_freq_write_src: assert property (@(posedge clock) disable iff (reset)
      f_we |-> (state_ff == S_CLEAR) || (state_ff == S_UPD) || (state_ff == S_RB_HALVE))
      else $error("count memory written outside its owning states");

   // no beat taken while a rebuild runs
   a_no_take_rebuild: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RB_BUILD) || (state_ff == S_RB_HALVE)) |-> !req_ready)
      else $error("beat accepted during rebuild");

   // a failed decode carries no symbol range
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.decode_fail) |->
         (rsp_ff.sym_freq == '0) && (rsp_ff.cum_low == '0) && (rsp_ff.symbol_out == '0))
      else $error("failed decode with non-zero range");

   // a result is only loaded into a free output slot
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result overwritten");

endmodule

FILE: src/order2_context_frequency_model.sv
// Order-2 adaptive context model for an arithmetic coder.
// Request channel (req_*) carries one beat per symbol: func selects encode of
// symbol_in or decode of target_count. Response channel (rsp_*) returns one beat
// per request with symbol, low, frequency and span under the two previous
// symbols, plus model_active and decode_fail flags.
// Counts and cumulative lows live in two synchronous memories of ALPHABET^3 words.
// Encode steps through span read, low read, upper read and update; decode adds a
// binary search between span and low, one cumulative-memory read per probe. The
// next request is accepted the cycle after the result is registered, unless a rebuild follows.
// After symbol 1000, 10000, 1000000 and each multiple of 100000000 a rebuild
// streams every row, plus two more row passes for each halving of an oversized
// context; no beat is taken meanwhile.
// Reset starts a clearing pass over all ALPHABET^3 words that loads all counts
// with one; req_ready stays low until it ends.
// A stalled receiver holds the result in the output register; the block then
// waits with the finished item until the slot frees.
module order2_context_frequency_model #(
   parameter int ALPHABET = o2cfm_pkg::ALPHABET_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  o2cfm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output o2cfm_pkg::rsp_type rsp_data
);

   import o2cfm_pkg::*;

   localparam int DEPTH  = ALPHABET * ALPHABET * ALPHABET;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              f_we, c_we;
   logic [ADDR_W-1:0] f_waddr, f_raddr, c_waddr, c_raddr;
   logic [CNT_W-1:0]  f_wdata, f_rdata, c_wdata, c_rdata;

   // sequencer
   o2cfm_seq #(.ALPHABET(ALPHABET)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .f_we      (f_we),
      .f_waddr   (f_waddr),
      .f_wdata   (f_wdata),
      .f_raddr   (f_raddr),
      .f_rdata   (f_rdata),
      .c_we      (c_we),
      .c_waddr   (c_waddr),
      .c_wdata   (c_wdata),
      .c_raddr   (c_raddr),
      .c_rdata   (c_rdata)
   );

   // live counts
   o2cfm_ram #(.DEPTH(DEPTH), .WIDTH(CNT_W)) u_freq_mem (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   // cumulative snapshot
   o2cfm_ram #(.DEPTH(DEPTH), .WIDTH(CNT_W)) u_cum_mem (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

endmodule
